/* design/olss_pkg.sv */
// shared types, operation and status codes for the ordered list store
package olss_pkg;

  // fixed field widths
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // default store depth
  localparam int unsigned DEFAULT_CAPACITY = 16;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHOW    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_EQUAL   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GREATER = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LESS    = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ITEM    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_NOPOS   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_NOMATCH = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd5;

  // one result item
  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          item_position;
    logic signed [VALUE_W-1:0] item_value;
    logic [COUNT_W-1:0]        element_count;
    logic                      last;
  } olss_result_t;

  // assemble a result item
  function automatic olss_result_t mk_result(
    input logic [STATUS_W-1:0]       status,
    input logic [POS_W-1:0]          pos,
    input logic signed [VALUE_W-1:0] val,
    input logic [COUNT_W-1:0]        cnt,
    input logic                      last
  );
    olss_result_t r;
    r.status        = status;
    r.item_position = pos;
    r.item_value    = val;
    r.element_count = cnt;
    r.last          = last;
    return r;
  endfunction

endpackage

/* design/olss_out_reg.sv */
// output holding register for result requests
module olss_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  olss_pkg::olss_result_t push_data,
  output logic                  can_push,
  output logic                  valid,
  input  logic                  ready,
  output olss_pkg::olss_result_t data
);
  import olss_pkg::*;

  // slot is free when empty or being drained this cycle
  assign can_push = !valid || ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_push) begin
      valid <= push;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push && can_push) begin
      data <= push_data;
    end
  end

endmodule

/* design/ordered_list_store_with_search_core.sv */
// top level: ordered list store with append, positional delete, count, show and search
//
// Requests enter on the s_ stream: s_tuser carries the operation, s_tdata the value
// and the 1-based delete position. Results leave on the m_ stream, one or more per
// request; m_tuser carries the status and m_tlast marks the final result of a request.
// A new request is taken only when the previous one has finished its work, but its
// results may still sit in the output register.
// Delete reads the removed entry, then moves each later entry down one place, one
// entry per cycle. Show and the searches walk the store through its single read port,
// one entry a cycle while no held match waits on a full output register. The store has
// one read and one write port, and its read data is registered.
// A search holds back its latest match so that the final one can carry tlast; a new
// match that must first send the held one pauses the walk, with the read data held,
// until the output register frees up. No result is lost or repeated under any stall.
// Reset empties the list (count to zero) and clears the control state; the store
// contents are not cleared and are never read before being written.
module ordered_list_store_with_search_core #(
  parameter int unsigned CAPACITY = olss_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  // request
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // value[31:0], position[36:32], zero fill
  input  logic [2:0]  s_tuser,  // mode[2:0]
  // result
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // item_position[4:0], item_value[36:5],
                                // element_count[41:37], zero fill
  output logic [2:0]  m_tuser,  // status[2:0]
  output logic        m_tlast
);
  import olss_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_DEL_FIRST = 3'd1;
  localparam logic [2:0] S_DEL_SHIFT = 3'd2;
  localparam logic [2:0] S_SCAN      = 3'd3;
  localparam logic [2:0] S_SCAN_END  = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;

  logic [2:0]                state;
  logic [CNT_W-1:0]          count;
  logic [IDX_W-1:0]          ptr;
  logic [MODE_W-1:0]         op;
  logic signed [VALUE_W-1:0] key;
  logic [POS_W-1:0]          del_pos;
  logic signed [VALUE_W-1:0] removed;
  olss_result_t              res;
  logic                      pend_valid;
  logic [POS_W-1:0]          pend_pos;
  logic signed [VALUE_W-1:0] pend_val;

  // request fields
  logic [MODE_W-1:0]         in_mode;
  logic signed [VALUE_W-1:0] in_value;
  logic [POS_W-1:0]          in_position;

  assign in_mode     = s_tuser[MODE_W-1:0];
  assign in_value    = s_tdata[VALUE_W-1:0];
  assign in_position = s_tdata[VALUE_W+POS_W-1:VALUE_W];

  // value store
  logic signed [VALUE_W-1:0] mem [CAPACITY];
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [IDX_W-1:0]          mem_raddr;
  logic signed [VALUE_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  // output register
  logic         push;
  olss_result_t push_data;
  logic         can_push;
  olss_result_t out_data;

  olss_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .can_push  (can_push),
    .valid     (m_tvalid),
    .ready     (m_tready),
    .data      (out_data)
  );

  assign m_tdata = {6'd0, out_data.element_count, out_data.item_value,
                    out_data.item_position};
  assign m_tuser = out_data.status;
  assign m_tlast = out_data.last;

  assign s_tready = (state == S_IDLE);

  // derived counts and compares
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] ptr1;
  logic [CMP_W-1:0] ptr2;
  logic [IDX_W-1:0] pos_idx;
  logic             full;
  logic             empty;
  logic             pos_bad;
  logic             more1;
  logic             more2;
  logic             match;
  logic             stall;
  logic [COUNT_W-1:0] cnt_inc;
  logic [COUNT_W-1:0] cnt_dec;
  logic [COUNT_W-1:0] cnt_out;

  assign cnt_ext = CMP_W'(count);
  assign pos_ext = CMP_W'(in_position);
  assign ptr1    = CMP_W'(ptr) + CMP_W'(1);
  assign ptr2    = CMP_W'(ptr) + CMP_W'(2);
  assign pos_idx = IDX_W'(pos_ext - CMP_W'(1));
  assign full    = (cnt_ext == CMP_W'(CAPACITY));
  assign empty   = (count == '0);
  assign pos_bad = (in_position == '0) || (pos_ext > cnt_ext);
  assign more1   = (ptr1 < cnt_ext);
  assign more2   = (ptr2 < cnt_ext);
  assign cnt_inc = COUNT_W'(cnt_ext + CMP_W'(1));
  assign cnt_dec = COUNT_W'(cnt_ext - CMP_W'(1));
  assign cnt_out = COUNT_W'(cnt_ext);

  // element test for show and searches
  always_comb begin
    unique case (op)
      MODE_SHOW:    match = 1'b1;
      MODE_EQUAL:   match = (mem_rdata == key);
      MODE_GREATER: match = (mem_rdata > key);
      MODE_LESS:    match = (mem_rdata < key);
      default:      match = 1'b0;
    endcase
  end

  // a new match must first send the held one
  assign stall = match && pend_valid && !can_push;

  // memory port and result push control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = ptr;
    push      = 1'b0;
    push_data = res;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          unique case (in_mode)
            MODE_APPEND: begin
              if (!full) begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(count);
                mem_wdata = in_value;
              end
            end
            MODE_DELETE: begin
              if (!empty && !pos_bad) begin
                mem_re    = 1'b1;
                mem_raddr = pos_idx;
              end
            end
            MODE_SHOW, MODE_EQUAL, MODE_GREATER, MODE_LESS: begin
              if (!empty) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DEL_FIRST: begin
        if (more1) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(ptr1);
        end
      end
      S_DEL_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr;
        mem_wdata = mem_rdata;
        if (more2) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(ptr2);
        end
      end
      S_SCAN: begin
        if (!stall && more1) begin
          mem_re    = 1'b1;
          mem_raddr = IDX_W'(ptr1);
        end
        push      = match && pend_valid && can_push;
        push_data = mk_result(STAT_ITEM, pend_pos, pend_val, cnt_out, 1'b0);
      end
      S_EMIT: begin
        push = can_push;
      end
      default: ;
    endcase
  end

  // sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op  <= in_mode;
            key <= in_value;
            unique case (in_mode)
              MODE_APPEND: begin
                if (full) begin
                  res <= mk_result(STAT_FULL, '0, '0, cnt_out, 1'b1);
                end else begin
                  count <= count + CNT_W'(1);
                  res   <= mk_result(STAT_OK, POS_W'(cnt_inc), in_value, cnt_inc, 1'b1);
                end
                state <= S_EMIT;
              end
              MODE_DELETE: begin
                if (empty) begin
                  res   <= mk_result(STAT_EMPTY, '0, '0, cnt_out, 1'b1);
                  state <= S_EMIT;
                end else if (pos_bad) begin
                  res   <= mk_result(STAT_NOPOS, '0, '0, cnt_out, 1'b1);
                  state <= S_EMIT;
                end else begin
                  ptr     <= pos_idx;
                  del_pos <= in_position;
                  state   <= S_DEL_FIRST;
                end
              end
              MODE_COUNT: begin
                res   <= mk_result(STAT_OK, '0, '0, cnt_out, 1'b1);
                state <= S_EMIT;
              end
              MODE_SHOW, MODE_EQUAL, MODE_GREATER, MODE_LESS: begin
                if (empty) begin
                  res   <= mk_result(STAT_EMPTY, '0, '0, cnt_out, 1'b1);
                  state <= S_EMIT;
                end else begin
                  ptr        <= '0;
                  pend_valid <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        // removed value arrives, start moving later entries down or finish if it was the last
        S_DEL_FIRST: begin
          removed <= mem_rdata;
          if (more1) begin
            state <= S_DEL_SHIFT;
          end else begin
            count <= count - CNT_W'(1);
            res   <= mk_result(STAT_OK, del_pos, mem_rdata, cnt_dec, 1'b1);
            state <= S_EMIT;
          end
        end
        // one entry moved per cycle
        S_DEL_SHIFT: begin
          ptr <= ptr + IDX_W'(1);
          if (!more2) begin
            count <= count - CNT_W'(1);
            res   <= mk_result(STAT_OK, del_pos, removed, cnt_dec, 1'b1);
            state <= S_EMIT;
          end
        end
        // walk the list, holding back the latest match
        S_SCAN: begin
          if (!stall) begin
            if (match) begin
              pend_valid <= 1'b1;
              pend_pos   <= POS_W'(ptr1);
              pend_val   <= mem_rdata;
            end
            if (more1) begin
              ptr <= ptr + IDX_W'(1);
            end else begin
              state <= S_SCAN_END;
            end
          end
        end
        // final match carries last, or report no match
        S_SCAN_END: begin
          if (pend_valid) begin
            res <= mk_result(STAT_ITEM, pend_pos, pend_val, cnt_out, 1'b1);
          end else begin
            res <= mk_result(STAT_NOMATCH, '0, '0, cnt_out, 1'b1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (can_push) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
